[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

[rtl/core/rlet_pkg.sv]
`default_nettype none
package rlet_pkg;

  localparam int unsigned MaxDescs = 1024;
  localparam int unsigned MaxBatch = 64;

  localparam logic [15:0] ErrHup = 16'h0018;
  localparam logic [15:0] OutBit = 16'h0004;

  typedef enum logic [2:0] {
    ActAssoc = 3'd0,
    ActDrop  = 3'd1,
    ActClose = 3'd2,
    ActClear = 3'd3,
    ActEvent = 3'd4,
    ActWait  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StReady    = 2'd1,
    StRejected = 2'd2
  } status_e;

  // Internal status code: a slot swap or move is still to be done.
  localparam logic [1:0] StSwapPend = 2'd3;

  // Main sequencer states.
  typedef enum logic [3:0] {
    SIdle,
    SLook,
    SReadS,
    SDecide,
    SReadB,
    SSwapW,
    SCloseA,
    SCloseB,
    SWaitRd,
    SWaitOut,
    SResp,
    SClrInit
  } state_e;

  // Packed slot record stored in one memory word.
  typedef struct packed {
    logic [15:0] desc;
    logic [15:0] interest;
    logic [15:0] fired;
    logic [31:0] token;
  } slot_t;

  function automatic logic is_ready(input slot_t s);
    return ((s.interest | ErrHup) & s.fired) != 16'h0000;
  endfunction

endpackage
`default_nettype wire

[rtl/core/ready_list_event_table_top.sv]
`default_nettype none
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | action, desc, event_mask, token, max_count
// out     | output    | out_valid/out_ready| status, entry_valid, ready_events,
//         |           |                    | ready_token, last
// How long an action takes is set by dependent reads and writes of the
// descriptor map and slot memories (one read port each). A wait reads each
// reported entry in turn from the slot memory read port.
// After reset a clearing pass over all MAX_DESCS entries empties the descriptor
// map; no item is taken meanwhile. A stalled output holds the sequencer.
module ready_list_event_table_top #(
  parameter int unsigned MAX_DESCS = rlet_pkg::MaxDescs,
  parameter int unsigned MAX_BATCH = rlet_pkg::MaxBatch
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action_i,
  input  wire logic [9:0]  desc_i,
  input  wire logic [15:0] event_mask_i,
  input  wire logic [31:0] token_i,
  input  wire logic [6:0]  max_count_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status_o,
  output logic             entry_valid_o,
  output logic [15:0]      ready_events_o,
  output logic [31:0]      ready_token_o,
  output logic             last_o
);
  import rlet_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(MAX_DESCS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned DW = 10;

  state_e state_q, state_d;

  // Latched request.
  logic [2:0]  act_q;
  logic [DW-1:0] desc_q;
  logic [15:0] mask_q;
  logic [31:0] tok_q;
  logic [6:0]  maxc_q;

  logic [CW-1:0] used_q, used_d, ready_q, ready_d;
  logic [CW-1:0] clr_q, clr_d;
  logic          in_range;
  logic          known_q, known_d;
  logic [AW-1:0] s_q, s_d, b_q, b_d;
  slot_t         sa_q, sa_d;
  logic [6:0]    n_q, n_d, i_q, i_d;
  logic [1:0]    st_q, st_d;

  // Output register.
  logic        ov_q, ov_d;
  logic [1:0]  ost_q, ost_d;
  logic        oev_q, oev_d;
  logic [15:0] oe_q, oe_d;
  logic [31:0] ot_q, ot_d;
  logic        ol_q, ol_d;

  // Map memory: bit AW is the mapped flag.
  logic          m_we;
  logic [AW-1:0] m_wa, m_ra;
  logic [AW:0]   m_wd, m_rd;
  // Slot memory.
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  slot_t         s_wd, s_rd;

  // Merged write ports, including the deferred second write of a swap.
  logic          pend_q;
  logic          pend_d;
  logic          s_we2, m_we2;
  logic [AW-1:0] s_wa2, m_wa2;
  slot_t         s_wd2;
  logic [AW:0]   m_wd2;

  rlet_ram #(.Width(AW + 1), .Depth(MAX_DESCS)) u_map (
    .clk_i(clk_i), .we_i(m_we2), .waddr_i(m_wa2), .wdata_i(m_wd2),
    .raddr_i(m_ra), .rdata_o(m_rd)
  );
  rlet_ram #(.Width($bits(slot_t)), .Depth(MAX_DESCS)) u_slot (
    .clk_i(clk_i), .we_i(s_we2), .waddr_i(s_wa2), .wdata_i(s_wd2),
    .raddr_i(s_ra), .rdata_o(s_rd)
  );

  assign in_ready = (state_q == SIdle);
  assign out_valid = ov_q;
  assign status_o = ost_q;
  assign entry_valid_o = oev_q;
  assign ready_events_o = oe_q;
  assign ready_token_o = ot_q;
  assign last_o = ol_q;

  assign in_range = ({{(32-DW){1'b0}}, desc_q} < MAX_DESCS);

  logic [AW-1:0] dq_idx, sa_didx, rd_didx;
  assign dq_idx  = AW'({{(32-DW){1'b0}}, desc_q});
  assign sa_didx = AW'(sa_q.desc);
  assign rd_didx = AW'(s_rd.desc);

  logic [CW-1:0] s_ext, b_ext;
  assign s_ext = {1'b0, s_q};
  assign b_ext = {1'b0, b_q};

  slot_t upd;
  logic  out_free;
  assign out_free = !ov_q || out_ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SClrInit: if (clr_q == CW'(MAX_DESCS - 1)) state_d = SIdle;
      SIdle:    if (in_valid) state_d = SLook;
      SLook: begin
        if (act_q == ActWait) state_d = (n_d == 7'd0) ? SResp : SWaitRd;
        else state_d = SReadS;
      end
      SReadS:  state_d = SDecide;
      SDecide: state_d = st_d == StSwapPend ? SReadB : SResp;
      SReadB:  state_d = SSwapW;
      SSwapW:  state_d = (act_q == ActClose) ? SCloseA : SResp;
      SCloseA: state_d = SCloseB;
      SCloseB: state_d = SResp;
      SWaitRd: state_d = SWaitOut;
      SWaitOut: if (out_free) state_d = (i_q + 7'd1 == n_q) ? SIdle : SWaitRd;
      SResp:   if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    used_d = used_q; ready_d = ready_q; clr_d = clr_q;
    known_d = known_q; s_d = s_q; b_d = b_q; sa_d = sa_q;
    n_d = n_q; i_d = i_q; st_d = st_q;
    ov_d = ov_q && !out_ready; ost_d = ost_q; oev_d = oev_q; oe_d = oe_q;
    ot_d = ot_q; ol_d = ol_q;
    m_we = 1'b0; m_wa = dq_idx; m_wd = '0; m_ra = dq_idx;
    s_we = 1'b0; s_wa = s_q; s_wd = sa_q; s_ra = s_q;
    upd = sa_q;
    n_d = (maxc_q > 7'(MAX_BATCH)) ? 7'(MAX_BATCH) : maxc_q;
    if ({{(CW-7){1'b0}}, n_d} > ready_q) n_d = ready_q[6:0];
    case (state_q)
      SClrInit: begin
        m_we = 1'b1; m_wa = clr_q[AW-1:0]; m_wd = '0;
        clr_d = clr_q + CW'(1);
      end
      SLook: begin
        m_ra = dq_idx; i_d = 7'd0; st_d = StDone;
      end
      SReadS: begin
        known_d = in_range && m_rd[AW];
        s_d = m_rd[AW-1:0];
        s_ra = m_rd[AW-1:0];
      end
      SDecide: begin
        st_d = StDone;
        upd = s_rd;
        if (act_q == ActAssoc) begin
          if (!in_range || (!known_q && used_q == CW'(MAX_DESCS))) begin
            st_d = StRejected;
          end else begin
            if (!known_q) begin
              s_d = used_q[AW-1:0];
              upd.desc = 16'(desc_q);
              upd.fired = OutBit;
              used_d = used_q + CW'(1);
              m_we = 1'b1; m_wd = {1'b1, used_q[AW-1:0]};
            end
            upd.interest = mask_q;
            upd.token = tok_q;
            s_we = 1'b1; s_wa = s_d; s_wd = upd;
            if (is_ready(upd)) begin
              st_d = StReady;
              if ({1'b0, s_d} >= ready_q) begin
                b_d = ready_q[AW-1:0]; ready_d = ready_q + CW'(1);
                if ({1'b0, s_d} != ready_q) st_d = StSwapPend;
              end
            end
          end
          // Swap keeps status 1 once done.
        end else if (known_q) begin
          case (act_q)
            ActDrop: begin
              upd.interest = 16'h0;
              s_we = 1'b1; s_wd = upd;
              if (s_ext < ready_q) begin
                b_d = AW'(ready_q - CW'(1)); ready_d = ready_q - CW'(1);
                if (s_ext != ready_q - CW'(1)) st_d = StSwapPend;
              end
            end
            ActClear: begin
              upd.fired = s_rd.fired & ~mask_q;
              s_we = 1'b1; s_wd = upd;
              if (s_ext < ready_q && !is_ready(upd)) begin
                b_d = AW'(ready_q - CW'(1)); ready_d = ready_q - CW'(1);
                if (s_ext != ready_q - CW'(1)) st_d = StSwapPend;
              end
            end
            ActEvent: begin
              upd.fired = s_rd.fired | mask_q;
              s_we = 1'b1; s_wd = upd;
              if (s_ext >= ready_q && is_ready(upd)) begin
                b_d = ready_q[AW-1:0]; ready_d = ready_q + CW'(1);
                if (s_ext != ready_q) st_d = StSwapPend;
              end
            end
            ActClose: begin
              m_we = 1'b1; m_wd = '0;
              used_d = used_q - CW'(1);
              if (s_ext < ready_q) begin
                ready_d = ready_q - CW'(1);
                b_d = AW'(ready_q - CW'(1));
                if (s_ext != ready_q - CW'(1)) st_d = StSwapPend;
                else begin
                  s_d = AW'(ready_q - CW'(1));
                  b_d = AW'(used_q - CW'(1));
                  if ({1'b0, s_d} != used_q - CW'(1)) st_d = StSwapPend;
                end
              end else begin
                b_d = AW'(used_q - CW'(1));
                if (s_ext != used_q - CW'(1)) st_d = StSwapPend;
              end
            end
            default: ;
          endcase
        end
        sa_d = upd;
        s_ra = b_d;
      end
      SReadB: begin
        s_ra = b_q;
      end
      SSwapW: begin
        // Slot s takes b's record; b takes the held record (not for close).
        s_we = 1'b1; s_wa = s_q; s_wd = s_rd;
        m_we = 1'b1; m_wa = rd_didx; m_wd = {1'b1, s_q};
        if (act_q == ActAssoc) st_d = StReady;
        else st_d = StDone;
        if (act_q == ActClose) begin
          // After a ready-area move, refill slot b from the used end.
          // used_q already holds the decremented count here.
          s_d = b_q;
          b_d = used_q[AW-1:0];
          if (b_ext == ready_q && b_ext < used_q && s_ext < b_ext) begin
            st_d = StSwapPend;
          end
          s_ra = used_q[AW-1:0];
        end
      end
      SCloseA: begin
        s_ra = b_q;
      end
      SCloseB: begin
        if (st_q == StSwapPend) begin
          s_we = 1'b1; s_wa = s_q; s_wd = s_rd;
          m_we = 1'b1; m_wa = rd_didx; m_wd = {1'b1, s_q};
        end
        st_d = StDone;
      end
      SWaitRd: s_ra = AW'(i_q);
      SWaitOut: begin
        s_ra = AW'(i_q);
        if (out_free) begin
          ov_d = 1'b1; ost_d = StDone; oev_d = 1'b1;
          oe_d = (s_rd.interest | ErrHup) & s_rd.fired;
          ot_d = s_rd.token; ol_d = (i_q + 7'd1 == n_q);
          i_d = i_q + 7'd1;
        end
      end
      SResp: begin
        if (out_free) begin
          ov_d = 1'b1; ost_d = (act_q == ActWait) ? StDone : st_q;
          oev_d = 1'b0; oe_d = '0; ot_d = '0; ol_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Deferred second write of a swap (one write port per memory).
  assign pend_d = (state_q == SSwapW) && (act_q != ActClose);

  always_comb begin
    s_we2 = s_we; s_wa2 = s_wa; s_wd2 = s_wd;
    m_we2 = m_we; m_wa2 = m_wa; m_wd2 = m_wd;
    if (pend_q) begin
      s_we2 = 1'b1; s_wa2 = b_q; s_wd2 = sa_q;
      m_we2 = 1'b1; m_wa2 = sa_didx; m_wd2 = {1'b1, b_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClrInit;
      clr_q <= '0; used_q <= '0; ready_q <= '0;
      ov_q <= 1'b0; pend_q <= 1'b0; st_q <= '0;
      known_q <= 1'b0; i_q <= '0; n_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d; used_q <= used_d; ready_q <= ready_d;
      ov_q <= ov_d; pend_q <= pend_d; st_q <= st_d;
      known_q <= known_d; i_q <= i_d; n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid) begin
      act_q <= action_i; desc_q <= desc_i; mask_q <= event_mask_i;
      tok_q <= token_i; maxc_q <= max_count_i;
    end
    s_q <= s_d; b_q <= b_d; sa_q <= sa_d;
    ost_q <= ost_d; oev_q <= oev_d; oe_q <= oe_d; ot_q <= ot_d; ol_q <= ol_d;
  end

  `ASSERT_ALWAYS(a_ready_le_used, clk_i, rst_ni, ready_q <= used_q)
  `ASSERT_ALWAYS(a_used_le_max, clk_i, rst_ni, used_q <= CW'(MAX_DESCS))
  `ASSERT_IMPL(a_no_take_in_clear, clk_i, rst_ni, state_q == SClrInit, !in_ready)

endmodule
`default_nettype wire

[rtl/core/rlet_ram.sv]
`default_nettype none
module rlet_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
